### hw/rtl/ccds_pkg.sv
// ----------------------------------------------------------------------------
// ccds_pkg
// Shared types, constants and character helpers for the Cache-Control
// directive scanner.
// ----------------------------------------------------------------------------
package ccds_pkg;

  localparam int WinDepth = 15;

  // window of recent folded bytes, element 0 is the oldest (most significant)
  typedef logic [0:WinDepth-1][7:0] win_t;

  localparam logic [8*15-1:0] TOK_MR = "must-revalidate";
  localparam logic [8*8-1:0]  TOK_NS = "no-store";
  localparam logic [8*8-1:0]  TOK_NC = "no-cache";
  localparam logic [8*7-1:0]  TOK_MA = "max-age";

  localparam logic [7:0] CH_EQ    = "=";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_SPACE = " ";
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_COMMA = ",";

  localparam logic [30:0] SAT_MAX = '1;
  localparam logic [31:0] MIN_NONE = '1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PRE_EQ,
    PH_POST_EQ,
    PH_NUM
  } phase_t;

  // one finished max-age value
  typedef struct packed {
    logic        fire;
    logic        nonpos;
    logic [30:0] value;
  } fin_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c inside {["A":"Z"]}) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c inside {CH_SPACE, CH_TAB};
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    return c inside {CH_COMMA, CH_SPACE, CH_TAB, CH_CR, CH_LF};
  endfunction

endpackage

### hw/rtl/ccds_if.sv
// ----------------------------------------------------------------------------
// ccds_if
// Valid/ready channels for header bytes in and merged results out.
// ----------------------------------------------------------------------------
interface ccds_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       has_byte;
  logic       line_end;
  logic       new_response;

  modport source (output valid, byte_value, has_byte, line_end, new_response,
                  input ready);
  modport sink (input valid, byte_value, has_byte, line_end, new_response,
                output ready);
endinterface

interface ccds_out_if;
  logic               valid;
  logic               ready;
  logic               no_disk;
  logic               revalidate;
  logic               age_seen;
  logic signed [31:0] age_min;

  modport source (output valid, no_disk, revalidate, age_seen, age_min,
                  input ready);
  modport sink (input valid, no_disk, revalidate, age_seen, age_min,
                output ready);
endinterface

### hw/rtl/ccds_cell.sv
// ----------------------------------------------------------------------------
// ccds_cell
// One byte of the recent-character window: folds case on entry, shifts
// toward the older neighbor and clears at line end.
// ----------------------------------------------------------------------------
module ccds_cell
  import ccds_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       shift_en,
  input  logic       clr,
  input  logic [7:0] d,
  output logic [7:0] q,
  output logic [7:0] shf
);

  logic [7:0] q_r;
  logic [7:0] q_nxt;

  assign shf   = shift_en ? fold_case(d) : q_r;
  assign q_nxt = clr ? 8'd0 : shf;
  assign q     = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= 8'd0;
    end else begin
      q_r <= q_nxt;
    end
  end

endmodule

### hw/rtl/ccds_value.sv
// ----------------------------------------------------------------------------
// ccds_value
// Parser for the max-age argument: blanks, '=', blanks, optional sign and a
// saturating decimal number. Reports each finished value.
// ----------------------------------------------------------------------------
module ccds_value
  import ccds_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic       lend_acc,
  input  logic       ma_hit,
  input  logic [7:0] b,
  output fin_t       fin
);

  phase_t      phase_r, phase_nxt, ph_mid;
  logic        neg_r, neg_nxt, neg_mid;
  logic        dig_r, dig_nxt, dig_mid;
  logic [30:0] accum_r, accum_nxt, acc_mid;
  logic        byte_fin, end_fin;
  logic [34:0] prod;

  assign prod = ({4'd0, accum_r} << 3) + ({4'd0, accum_r} << 1) + {31'd0, b[3:0]};

  // next state
  always_comb begin
    ph_mid = phase_r;
    if (step) begin
      case (phase_r)
        PH_PRE_EQ: begin
          if (b == CH_EQ) begin
            ph_mid = PH_POST_EQ;
          end else if (!is_blank(b)) begin
            ph_mid = PH_IDLE;
          end
        end
        PH_POST_EQ: begin
          if (!is_blank(b)) begin
            if (b == CH_MINUS || b == CH_PLUS || is_digit(b)) begin
              ph_mid = PH_NUM;
            end else begin
              ph_mid = PH_IDLE;
            end
          end
        end
        PH_NUM: begin
          if (!is_digit(b)) begin
            ph_mid = PH_IDLE;
          end
        end
        default: begin
          ph_mid = phase_r;
        end
      endcase
    end
    if (ma_hit) begin
      ph_mid = PH_PRE_EQ;
    end
    phase_nxt = lend_acc ? PH_IDLE : ph_mid;
  end

  // value data and finish report
  always_comb begin
    neg_mid  = neg_r;
    dig_mid  = dig_r;
    acc_mid  = accum_r;
    byte_fin = 1'b0;
    if (step) begin
      case (phase_r)
        PH_POST_EQ: begin
          if (b == CH_MINUS) begin
            neg_mid = 1'b1;
          end else if (is_digit(b)) begin
            dig_mid = 1'b1;
            acc_mid = {27'd0, b[3:0]};
          end
        end
        PH_NUM: begin
          if (is_digit(b)) begin
            dig_mid = 1'b1;
            acc_mid = (prod > {4'd0, SAT_MAX}) ? SAT_MAX : prod[30:0];
          end else begin
            byte_fin = dig_r;
            neg_mid  = 1'b0;
            dig_mid  = 1'b0;
            acc_mid  = '0;
          end
        end
        default: begin
          neg_mid = neg_r;
        end
      endcase
    end
    if (ma_hit) begin
      neg_mid = 1'b0;
      dig_mid = 1'b0;
      acc_mid = '0;
    end
    end_fin    = lend_acc && (ph_mid == PH_NUM) && dig_mid;
    fin.fire   = byte_fin | end_fin;
    fin.nonpos = byte_fin ? (neg_r | (accum_r == '0)) : (neg_mid | (acc_mid == '0));
    fin.value  = byte_fin ? accum_r : acc_mid;
    neg_nxt    = lend_acc ? 1'b0 : neg_mid;
    dig_nxt    = lend_acc ? 1'b0 : dig_mid;
    accum_nxt  = lend_acc ? '0 : acc_mid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      neg_r   <= 1'b0;
      dig_r   <= 1'b0;
      accum_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      dig_r   <= dig_nxt;
      accum_r <= accum_nxt;
    end
  end

endmodule

### hw/rtl/cache_control_directive_scan.sv
// ----------------------------------------------------------------------------
// cache_control_directive_scan
// Scans Cache-Control header bytes for caching directives and merges the
// per-line findings into a per-response result.
// ----------------------------------------------------------------------------
// One header byte is taken per cycle and each item finishes in the cycle it
// is accepted: a 15-cell shift chain holds the recent case-folded bytes and
// is compared against the directive names in parallel, while the max-age
// number is accumulated alongside. An item carrying line_end produces one
// result, held in the output register until taken; input stalls only while
// that result waits and a new item cannot be passed through. The result is
// registered and appears in the cycle after its line-end item is accepted.
module cache_control_directive_scan
  import ccds_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  ccds_in_if.sink     in_ch,
  ccds_out_if.source  out_ch
);

  win_t        win_q, win_shf;
  logic        acc, step, lend_acc, ma_hit, delim_hit;
  logic        mr_hit, forbid_hit;
  fin_t        fin;
  logic [1:0]  line_flags_r, line_flags_nxt, lf_mid;
  logic [31:0] line_min_r, line_min_nxt, lm_mid;
  logic [2:0]  merged_flags_r, merged_flags_nxt, mf;
  logic [31:0] merged_min_r, merged_min_nxt, mm;
  logic        out_valid_r, out_valid_nxt;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign acc         = in_ch.valid && in_ch.ready;
  assign step        = acc && in_ch.has_byte;
  assign lend_acc    = acc && in_ch.line_end;

  for (genvar k = 0; k < WinDepth; k++) begin : g_cell
    logic [7:0] d_in;
    if (k == WinDepth - 1) begin : g_head
      assign d_in = in_ch.byte_value;
    end else begin : g_body
      assign d_in = win_q[k+1];
    end
    ccds_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (step),
      .clr      (lend_acc),
      .d        (d_in),
      .q        (win_q[k]),
      .shf      (win_shf[k])
    );
  end

  assign ma_hit    = step && (win_shf[8:14] == TOK_MA);
  assign delim_hit = step && is_delim(in_ch.byte_value);

  // a delimiter checks the window before it; line end checks it after
  assign mr_hit = (delim_hit && (win_q == TOK_MR)) || (lend_acc && (win_shf == TOK_MR));
  assign forbid_hit =
      (delim_hit && ((win_q[7:14] == TOK_NS) || (win_q[7:14] == TOK_NC))) ||
      (lend_acc && ((win_shf[7:14] == TOK_NS) || (win_shf[7:14] == TOK_NC)));

  ccds_value u_value (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .lend_acc (lend_acc),
    .ma_hit   (ma_hit),
    .b        (in_ch.byte_value),
    .fin      (fin)
  );

  always_comb begin
    lf_mid = line_flags_r | {mr_hit, forbid_hit | (fin.fire & fin.nonpos)};
    lm_mid = line_min_r;
    if (fin.fire && !fin.nonpos && ({1'b0, fin.value} < line_min_r)) begin
      lm_mid = {1'b0, fin.value};
    end

    mf = in_ch.new_response ? 3'd0 : merged_flags_r;
    mm = in_ch.new_response ? MIN_NONE : merged_min_r;
    mf[1:0] = mf[1:0] | lf_mid;
    if (lm_mid != MIN_NONE) begin
      if (!mf[2] || (lm_mid < mm)) begin
        mm    = lm_mid;
        mf[2] = 1'b1;
      end
    end

    line_flags_nxt   = lend_acc ? 2'd0 : lf_mid;
    line_min_nxt     = lend_acc ? MIN_NONE : lm_mid;
    merged_flags_nxt = lend_acc ? mf : merged_flags_r;
    merged_min_nxt   = lend_acc ? mm : merged_min_r;
    out_valid_nxt    = lend_acc || (out_valid_r && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_flags_r   <= 2'd0;
      line_min_r     <= MIN_NONE;
      merged_flags_r <= 3'd0;
      merged_min_r   <= MIN_NONE;
      out_valid_r    <= 1'b0;
    end else begin
      line_flags_r   <= line_flags_nxt;
      line_min_r     <= line_min_nxt;
      merged_flags_r <= merged_flags_nxt;
      merged_min_r   <= merged_min_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // merged state only changes on a line end, so it doubles as the result
  assign out_ch.valid      = out_valid_r;
  assign out_ch.no_disk    = merged_flags_r[0];
  assign out_ch.revalidate = merged_flags_r[1];
  assign out_ch.age_seen   = merged_flags_r[2];
  assign out_ch.age_min    = $signed(merged_min_r);

`ifndef SYNTHESIS
  a_min_matches_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (merged_flags_r[2] == (merged_min_r != MIN_NONE)))
    else $error("merged minimum disagrees with positive max-age flag");

  a_min_positive: assert property (@(posedge clk) disable iff (!rst_n)
    merged_flags_r[2] |-> (!merged_min_r[31] && (merged_min_r != 32'd0)))
    else $error("merged minimum is not a positive value");

  a_result_follows_line_end: assert property (@(posedge clk) disable iff (!rst_n)
    lend_acc |=> out_valid_r)
    else $error("line end accepted without a result");

  a_line_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    lend_acc |=> ((line_flags_r == 2'd0) && (line_min_r == MIN_NONE) && (win_q == '0)))
    else $error("line state not cleared after line end");
`endif

endmodule
